// File: rtl/tak_pkg.sv
// Package with the types, constants and saturation helpers of the tilt Kalman filter.
package tak_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned RW = 31;
  localparam int unsigned WW = 50;
  localparam int unsigned RND_W = 48;
  localparam int unsigned DIV_BITS = 48;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);
  localparam int unsigned MAC_IDX_W = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [RW-1:0] APN_RESET = RW'(66);
  localparam logic [RW-1:0] BPN_RESET = RW'(197);
  localparam logic [RW-1:0] MN_RESET = RW'(32768);
  localparam logic [RW-1:0] TS_RESET = RW'(655);
  localparam logic signed [QW-1:0] Q_ONE = QW'(65536);

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd3;

  localparam logic [MAC_IDX_W-1:0] MAC_PRED_ANGLE = 4'd0;
  localparam logic [MAC_IDX_W-1:0] MAC_PRED_CAA = 4'd1;
  localparam logic [MAC_IDX_W-1:0] MAC_PRED_CAB = 4'd2;
  localparam logic [MAC_IDX_W-1:0] MAC_PRED_CBA = 4'd3;
  localparam logic [MAC_IDX_W-1:0] MAC_PRED_CBB = 4'd4;
  localparam logic [MAC_IDX_W-1:0] MAC_UPD_CAA = 4'd5;
  localparam logic [MAC_IDX_W-1:0] MAC_UPD_CAB = 4'd6;
  localparam logic [MAC_IDX_W-1:0] MAC_UPD_CBA = 4'd7;
  localparam logic [MAC_IDX_W-1:0] MAC_UPD_CBB = 4'd8;
  localparam logic [MAC_IDX_W-1:0] MAC_UPD_ANGLE = 4'd9;
  localparam logic [MAC_IDX_W-1:0] MAC_UPD_BIAS = 4'd10;

  typedef struct packed {
    logic signed [QW-1:0] accel_angle;
    logic signed [QW-1:0] gyro_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [QW-1:0] angle_estimate;
    logic signed [QW-1:0] rate_estimate;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_D0,
    ST_MAC,
    ST_MWAIT,
    ST_ERR,
    ST_DIV,
    ST_DWAIT,
    ST_OUT
  } state_e;

  function automatic logic signed [WW-1:0] ext_s(input logic signed [QW-1:0] x);
    return {{(WW-QW){x[QW-1]}}, x};
  endfunction

  function automatic logic signed [WW-1:0] ext_u(input logic [RW-1:0] x);
    return {{(WW-RW){1'b0}}, x};
  endfunction

  function automatic logic signed [QW-1:0] sat_q(input logic signed [WW-1:0] v);
    logic signed [QW-1:0] r;
    if (v[WW-1:QW-1] == {(WW-QW+1){1'b0}} || v[WW-1:QW-1] == {(WW-QW+1){1'b1}}) begin
      r = v[QW-1:0];
    end else if (v[WW-1]) begin
      r = {1'b1, {(QW-1){1'b0}}};
    end else begin
      r = {1'b0, {(QW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: rtl/tak_mac.sv
// Shared three-stage fixed-point multiply, round and saturating accumulate unit.
module tak_mac (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [tak_pkg::QW-1:0] a_i,
  input  logic signed [tak_pkg::QW-1:0] b_i,
  input  logic signed [tak_pkg::QW-1:0] acc_i,
  input  logic                         sub_i,
  output logic                         done_o,
  output logic signed [tak_pkg::QW-1:0] res_o
);
  import tak_pkg::*;

  logic signed [2*QW-1:0] prod_q, rsum;
  logic signed [RND_W-1:0] rnd_q;
  logic signed [QW-1:0] acc1_q, acc2_q, res_q;
  logic sub1_q, sub2_q;
  logic v1_q, v2_q, v3_q;
  logic signed [WW-1:0] rnd_ext, total;

  always_comb begin
    rsum = prod_q + (prod_q[2*QW-1] ? 64'sd32767 : 64'sd32768);
    rnd_ext = {{(WW-RND_W){rnd_q[RND_W-1]}}, rnd_q};
    total = sub2_q ? (ext_s(acc2_q) - rnd_ext) : (ext_s(acc2_q) + rnd_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    acc1_q <= acc_i;
    sub1_q <= sub_i;
    rnd_q <= rsum[2*QW-1:16];
    acc2_q <= acc1_q;
    sub2_q <= sub1_q;
    res_q <= sat_q(total);
  end

  assign done_o = v3_q;
  assign res_o = res_q;

endmodule

// File: rtl/tak_div.sv
// Bit-serial restoring divider for the saturated Q16.16 gain quotient.
module tak_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [tak_pkg::QW-1:0] num_i,
  input  logic [tak_pkg::RW-1:0]       den_i,
  output logic                         done_o,
  output logic signed [tak_pkg::QW-1:0] quo_o
);
  import tak_pkg::*;

  logic busy_q, done_q, neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_BITS-1:0] num_q;
  logic [RW-1:0] rem_q, den_q;
  logic [QW-1:0] mag;
  logic [QW-1:0] trial;
  logic [QW:0] diff;
  logic [DIV_BITS-1:0] start_num;

  always_comb begin
    mag = num_i[QW-1] ? QW'(-num_i) : QW'(num_i);
    start_num = {mag, 16'b0} + {{(DIV_BITS-RW+1){1'b0}}, den_i[RW-1:1]};
    trial = {rem_q, num_q[DIV_BITS-1]};
    diff = {1'b0, trial} - {2'b0, den_q};
    if (num_q[DIV_BITS-1:QW-1] != '0) begin
      quo_o = neg_q ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else if (neg_q) begin
      quo_o = -$signed({1'b0, num_q[QW-2:0]});
    end else begin
      quo_o = $signed({1'b0, num_q[QW-2:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(DIV_BITS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_BITS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= start_num;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[QW-1];
    end else if (busy_q) begin
      num_q <= {num_q[DIV_BITS-2:0], ~diff[QW]};
      rem_q <= diff[QW] ? trial[RW-1:0] : diff[RW-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// File: rtl/tilt_angle_kalman_filter.sv
// Top level of the two-state tilt Kalman filter with its step sequencer.
//
// Channel  Direction  Handshake                  Payload
// input    in         in_valid_i / in_ready_o    tak_pkg::in_item_t
// output   out        out_valid_o / out_ready_i  tak_pkg::out_item_t
// config   in         cfg_we_i                   cfg_idx_i, cfg_data_i
//
// Between its transfer and the next ready state, each sample runs eleven passes
// through the shared three-stage multiplier and two divisions of 48 shift steps
// each plus start and finish. Without a positive innovation variance the
// divisions are skipped.
// Reset restores the filter state and the registers at once.
// A result that is not taken holds the filter in its last step.
module tilt_angle_kalman_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tak_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tak_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [tak_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tak_pkg::RW-1:0]         cfg_data_i
);
  import tak_pkg::*;

  state_e state_q, state_d;
  logic [MAC_IDX_W-1:0] mac_idx_q, mac_idx_d;
  logic div_idx_q, div_idx_d;
  logic [RW-1:0] apn_q, bpn_q, mn_q, ts_q;
  logic signed [QW-1:0] angle_q, angle_d, bias_q, bias_d;
  logic signed [QW-1:0] caa_q, caa_d, cab_q, cab_d, cba_q, cba_d, cbb_q, cbb_d;
  logic signed [QW-1:0] x_q, x_d, nb_q, nb_d, e_q, e_d;
  logic signed [QW-1:0] k0_q, k0_d, k1_q, k1_d, t0_q, t0_d, t1_q, t1_d;
  in_item_t in_q;
  out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic mac_start, mac_done, mac_sub, div_start, div_done;
  logic signed [QW-1:0] mac_a, mac_b, mac_acc, mac_res, div_num, div_quo;

  tak_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .a_i     (mac_a),
    .b_i     (mac_b),
    .acc_i   (mac_acc),
    .sub_i   (mac_sub),
    .done_o  (mac_done),
    .res_o   (mac_res)
  );

  tak_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (e_q[RW-1:0]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    mac_acc = angle_q;
    mac_a = x_q;
    mac_b = $signed({1'b0, ts_q});
    mac_sub = 1'b0;
    case (mac_idx_q)
      MAC_PRED_ANGLE: begin
        mac_acc = angle_q;
      end
      MAC_PRED_CAA: begin
        mac_acc = caa_q;
      end
      MAC_PRED_CAB: begin
        mac_acc = cab_q;
        mac_a = nb_q;
      end
      MAC_PRED_CBA: begin
        mac_acc = cba_q;
        mac_a = nb_q;
      end
      MAC_PRED_CBB: begin
        mac_acc = cbb_q;
        mac_a = $signed({1'b0, bpn_q});
      end
      MAC_UPD_CAA: begin
        mac_acc = caa_q;
        mac_a = k0_q;
        mac_b = t0_q;
        mac_sub = 1'b1;
      end
      MAC_UPD_CAB: begin
        mac_acc = cab_q;
        mac_a = k0_q;
        mac_b = t1_q;
        mac_sub = 1'b1;
      end
      MAC_UPD_CBA: begin
        mac_acc = cba_q;
        mac_a = k1_q;
        mac_b = t0_q;
        mac_sub = 1'b1;
      end
      MAC_UPD_CBB: begin
        mac_acc = cbb_q;
        mac_a = k1_q;
        mac_b = t1_q;
        mac_sub = 1'b1;
      end
      MAC_UPD_ANGLE: begin
        mac_acc = angle_q;
        mac_a = k0_q;
        mac_b = x_q;
      end
      MAC_UPD_BIAS: begin
        mac_acc = bias_q;
        mac_a = k1_q;
        mac_b = x_q;
      end
      default: begin
        mac_acc = angle_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    mac_idx_d = mac_idx_q;
    div_idx_d = div_idx_q;
    angle_d = angle_q;
    bias_d = bias_q;
    caa_d = caa_q;
    cab_d = cab_q;
    cba_d = cba_q;
    cbb_d = cbb_q;
    x_d = x_q;
    nb_d = nb_q;
    e_d = e_q;
    k0_d = k0_q;
    k1_d = k1_q;
    t0_d = t0_q;
    t1_d = t1_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mac_start = 1'b0;
    div_start = 1'b0;
    div_num = div_idx_q ? cba_q : caa_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_RATE;
        end
      end
      ST_RATE: begin
        x_d = sat_q(ext_s(in_q.gyro_rate) - ext_s(bias_q));
        mac_idx_d = MAC_PRED_ANGLE;
        state_d = ST_MAC;
      end
      ST_D0: begin
        x_d = sat_q(ext_u(apn_q) - ext_s(cab_q) - ext_s(cba_q));
        nb_d = sat_q(-ext_s(cbb_q));
        mac_idx_d = MAC_PRED_CAA;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        mac_start = 1'b1;
        state_d = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mac_done) begin
          mac_idx_d = mac_idx_q + 1'b1;
          state_d = ST_MAC;
          case (mac_idx_q)
            MAC_PRED_ANGLE: begin
              angle_d = mac_res;
              state_d = ST_D0;
            end
            MAC_PRED_CAA: caa_d = mac_res;
            MAC_PRED_CAB: cab_d = mac_res;
            MAC_PRED_CBA: cba_d = mac_res;
            MAC_PRED_CBB: begin
              cbb_d = mac_res;
              state_d = ST_ERR;
            end
            MAC_UPD_CAA: caa_d = mac_res;
            MAC_UPD_CAB: cab_d = mac_res;
            MAC_UPD_CBA: cba_d = mac_res;
            MAC_UPD_CBB: cbb_d = mac_res;
            MAC_UPD_ANGLE: angle_d = mac_res;
            MAC_UPD_BIAS: begin
              bias_d = mac_res;
              state_d = ST_OUT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ERR: begin
        x_d = sat_q(ext_s(in_q.accel_angle) - ext_s(angle_q));
        e_d = sat_q(ext_u(mn_q) + ext_s(caa_q));
        t0_d = caa_q;
        t1_d = cab_q;
        k0_d = '0;
        k1_d = '0;
        div_idx_d = 1'b0;
        mac_idx_d = MAC_UPD_CAA;
        if (sat_q(ext_u(mn_q) + ext_s(caa_q)) > 0) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_MAC;
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          if (div_idx_q) begin
            k1_d = div_quo;
            state_d = ST_MAC;
          end else begin
            k0_d = div_quo;
            div_idx_d = 1'b1;
            state_d = ST_DIV;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.angle_estimate = angle_q;
          out_d.rate_estimate = sat_q(ext_s(in_q.gyro_rate) - ext_s(bias_q));
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mac_idx_q <= '0;
      div_idx_q <= 1'b0;
      out_valid_q <= 1'b0;
      apn_q <= APN_RESET;
      bpn_q <= BPN_RESET;
      mn_q <= MN_RESET;
      ts_q <= TS_RESET;
      angle_q <= '0;
      bias_q <= '0;
      caa_q <= Q_ONE;
      cab_q <= '0;
      cba_q <= '0;
      cbb_q <= Q_ONE;
    end else begin
      state_q <= state_d;
      mac_idx_q <= mac_idx_d;
      div_idx_q <= div_idx_d;
      out_valid_q <= out_valid_d;
      angle_q <= angle_d;
      bias_q <= bias_d;
      caa_q <= caa_d;
      cab_q <= cab_d;
      cba_q <= cba_d;
      cbb_q <= cbb_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ANGLE_NOISE: apn_q <= cfg_data_i;
          CFG_BIAS_NOISE: bpn_q <= cfg_data_i;
          CFG_MEAS_NOISE: mn_q <= cfg_data_i;
          CFG_TIME_STEP: ts_q <= cfg_data_i;
          default: apn_q <= apn_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    x_q <= x_d;
    nb_q <= nb_d;
    e_q <= e_d;
    k0_q <= k0_d;
    k1_q <= k1_d;
    t0_q <= t0_d;
    t1_q <= t1_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

// File: rtl/tak_checker.sv
// Port-level checker for the tilt Kalman filter and its bind to the top level.
module tak_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tak_pkg::out_item_t  out_data_o
);
  import tak_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled output transfer changed.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("Input ready returned too soon after a transfer.");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("Result appeared while the filter was idle.");

endmodule

bind tilt_angle_kalman_filter tak_checker u_tak_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
